// ===== src/lspg_pkg.sv =====
// Shared types, constants and color wheel function for the LED strip pattern generator.
package lspg_pkg;

    localparam int DEF_NUM_PIXELS = 64;
    localparam int DEF_DESC_DEPTH = 2;

    localparam int IDX_W = 6;
    localparam int COLOR_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COLOR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PERIOD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_START = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_START = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHASER_SPAN = 3'd6;

    localparam logic [15:0] RST_SIGNED_PERIOD = 16'd1000;
    localparam logic [14:0] RST_MIN_PERIOD = 15'd10;
    localparam logic [7:0] RST_RIGHT_START = 8'd97;
    localparam logic [7:0] RST_LEFT_START = 8'd18;
    localparam logic [6:0] RST_CHASER_SPAN = 7'd30;

    localparam logic [7:0] WHEEL_THIRD = 8'd85;
    localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;
    localparam logic [7:0] PHASE_LAST = 8'd254;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_SOLID = 2'd1,
        MODE_RAINBOW = 2'd2,
        MODE_CHASER = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic [COLOR_W-1:0] color;
        logic [7:0] phase;
        logic hit_a_ok;
        logic [IDX_W-1:0] hit_a;
        logic hit_b_ok;
        logic [IDX_W-1:0] hit_b;
    } frame_desc_t;

    function automatic logic [COLOR_W-1:0] wheel(input logic [7:0] v);
        logic [7:0] w;
        logic [7:0] d;
        logic [7:0] t;
        w = ~v;
        if (w < WHEEL_THIRD)
        begin
            t = (w << 1) + w;
            wheel = {8'd255 - t, 8'd0, t};
        end
        else if (w < WHEEL_TWO_THIRDS)
        begin
            d = w - WHEEL_THIRD;
            t = (d << 1) + d;
            wheel = {8'd0, t, 8'd255 - t};
        end
        else
        begin
            d = w - WHEEL_TWO_THIRDS;
            t = (d << 1) + d;
            wheel = {t, 8'd255 - t, 8'd0};
        end
    endfunction

endpackage

// ===== src/lspg_front.sv =====
// Front end: config registers, tick counting, frame decision and frame descriptor build.
module lspg_front #(
    parameter int NUM_PIXELS = lspg_pkg::DEF_NUM_PIXELS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               force_update,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lspg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lspg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               fifo_full,
    output logic                               desc_push,
    output lspg_pkg::frame_desc_t              desc
);

    lspg_pkg::mode_t mode_reg;
    logic [15:0] period_reg;
    logic [23:0] color_reg;
    logic [14:0] min_reg;
    logic [7:0] right_reg;
    logic [7:0] left_reg;
    logic [6:0] span_reg;

    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0] phase_reg, phase_next;
    logic [7:0] step_reg, step_next;

    logic accept;
    logic render;
    logic negative;
    logic [15:0] mag;
    logic [15:0] period;
    logic [15:0] elapsed_inc;
    logic [7:0] step_inc;
    logic [lspg_pkg::POS_W-1:0] pos_a;
    logic [lspg_pkg::POS_W-1:0] pos_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lspg_pkg::MODE_OFF;
            period_reg <= lspg_pkg::RST_SIGNED_PERIOD;
            color_reg <= '0;
            min_reg <= lspg_pkg::RST_MIN_PERIOD;
            right_reg <= lspg_pkg::RST_RIGHT_START;
            left_reg <= lspg_pkg::RST_LEFT_START;
            span_reg <= lspg_pkg::RST_CHASER_SPAN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lspg_pkg::CFG_PATTERN_MODE: mode_reg <= lspg_pkg::mode_t'(cfg_data[1:0]);
                lspg_pkg::CFG_SIGNED_PERIOD: period_reg <= cfg_data[15:0];
                lspg_pkg::CFG_PIXEL_COLOR: color_reg <= cfg_data[23:0];
                lspg_pkg::CFG_MIN_PERIOD: min_reg <= cfg_data[14:0];
                lspg_pkg::CFG_RIGHT_START: right_reg <= cfg_data[7:0];
                lspg_pkg::CFG_LEFT_START: left_reg <= cfg_data[7:0];
                lspg_pkg::CFG_CHASER_SPAN: span_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        negative = period_reg[15];
        mag = negative ? (~period_reg + 16'd1) : period_reg;
        period = (mag < {1'b0, min_reg}) ? {1'b0, min_reg} : mag;
        elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        render = (elapsed_inc > period) || force_update;
        accept = push && !fifo_full;
        desc_push = accept && render;

        if (!negative)
        begin
            pos_a = {2'b0, right_reg} - {3'b0, span_reg} + {2'b0, step_reg};
            pos_b = {2'b0, left_reg} + {3'b0, span_reg} - {2'b0, step_reg};
        end
        else
        begin
            pos_a = {2'b0, right_reg} - {2'b0, step_reg};
            pos_b = {2'b0, left_reg} + {2'b0, step_reg};
        end

        desc.mode = mode_reg;
        desc.color = (mode_reg == lspg_pkg::MODE_OFF) ? '0 : color_reg;
        desc.phase = phase_reg;
        desc.hit_a_ok = !pos_a[lspg_pkg::POS_W-1]
                        && (pos_a < lspg_pkg::POS_W'(NUM_PIXELS));
        desc.hit_a = pos_a[lspg_pkg::IDX_W-1:0];
        desc.hit_b_ok = !pos_b[lspg_pkg::POS_W-1]
                        && (pos_b < lspg_pkg::POS_W'(NUM_PIXELS));
        desc.hit_b = pos_b[lspg_pkg::IDX_W-1:0];

        step_inc = step_reg + 8'd1;
        elapsed_next = elapsed_reg;
        phase_next = phase_reg;
        step_next = step_reg;
        if (accept)
        begin
            elapsed_next = render ? 16'd0 : elapsed_inc;
            if (render && (mode_reg == lspg_pkg::MODE_RAINBOW))
                phase_next = (phase_reg == lspg_pkg::PHASE_LAST) ? 8'd0 : phase_reg + 8'd1;
            if (render && (mode_reg == lspg_pkg::MODE_CHASER))
                step_next = (step_inc > {1'b0, span_reg}) ? 8'd0 : step_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            phase_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            phase_reg <= phase_next;
            step_reg <= step_next;
        end
    end

endmodule

// ===== src/lspg_desc_fifo.sv =====
// Short queue of frame descriptors between the front end and the pixel sequencer.
module lspg_desc_fifo #(
    parameter int DEPTH = lspg_pkg::DEF_DESC_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  lspg_pkg::frame_desc_t wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output lspg_pkg::frame_desc_t rd_data,
    output logic                  nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lspg_pkg::frame_desc_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/lspg_back.sv =====
// Pixel sequencer: walks a frame descriptor pixel by pixel into the result register.
module lspg_back #(
    parameter int NUM_PIXELS = lspg_pkg::DEF_NUM_PIXELS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             desc_nonempty,
    input  lspg_pkg::frame_desc_t            desc,
    output logic                             desc_take,
    input  logic                             pop,
    output logic                             empty,
    output logic [lspg_pkg::IDX_W-1:0]       pixel_index,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             last_pixel
);

    localparam logic [lspg_pkg::IDX_W-1:0] LAST_IDX = lspg_pkg::IDX_W'(NUM_PIXELS - 1);

    lspg_pkg::frame_desc_t cur_reg;
    logic active_reg, active_next;
    logic [lspg_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic [lspg_pkg::IDX_W-1:0] idx_reg;
    logic [lspg_pkg::COLOR_W-1:0] color_reg;
    logic last_reg;

    logic out_free;
    logic adv;
    logic is_last;
    logic [lspg_pkg::COLOR_W-1:0] pix_color;

    always_comb
    begin
        out_free = !out_valid_reg || pop;
        adv = active_reg && out_free;
        is_last = (cnt_reg == LAST_IDX);
        desc_take = desc_nonempty && (!active_reg || (adv && is_last));

        unique case (cur_reg.mode)
            lspg_pkg::MODE_OFF: pix_color = '0;
            lspg_pkg::MODE_SOLID: pix_color = cur_reg.color;
            lspg_pkg::MODE_RAINBOW: pix_color = lspg_pkg::wheel({2'b0, cnt_reg} + cur_reg.phase);
            lspg_pkg::MODE_CHASER:
                pix_color = ((cur_reg.hit_a_ok && (cur_reg.hit_a == cnt_reg))
                             || (cur_reg.hit_b_ok && (cur_reg.hit_b == cnt_reg)))
                            ? cur_reg.color : '0;
        endcase

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;

        cnt_next = cnt_reg;
        active_next = active_reg;
        if (desc_take)
        begin
            cnt_next = '0;
            active_next = 1'b1;
        end
        else if (adv)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (is_last)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_take)
            cur_reg <= desc;
        if (adv)
        begin
            idx_reg <= cnt_reg;
            color_reg <= pix_color;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty = !out_valid_reg;
    assign pixel_index = idx_reg;
    assign red = color_reg[23:16];
    assign green = color_reg[15:8];
    assign blue = color_reg[7:0];
    assign last_pixel = last_reg;

    // pixel counter stays on the strip
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg <= LAST_IDX))
        else $error("pixel counter past last pixel");

    // last flag only on the final pixel
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (idx_reg == LAST_IDX))
        else $error("last_pixel on wrong index");

    // a new frame starts at pixel zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        desc_take |=> (active_reg && (cnt_reg == '0)))
        else $error("frame did not start at pixel zero");

    // finishing a frame with nothing queued leaves the sequencer idle
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && is_last && !desc_nonempty) |=> !active_reg)
        else $error("sequencer still active after last pixel");

endmodule

// ===== src/led_strip_pattern_generator_top.sv =====
// Top level of the LED strip pattern generator: front end, descriptor queue, pixel sequencer.
// A tick that starts a frame queues a descriptor; the pixel sequencer then emits NUM_PIXELS
// result beats, one per cycle while results are popped, set by its pixel counter, and moves
// on to a queued frame with no gap. Ticks keep flowing while a frame is drawn; full rises only
// when DESC_DEPTH frames are waiting. Config writes are always ready and must only be made
// while the block is idle.
module led_strip_pattern_generator_top #(
    parameter int NUM_PIXELS = lspg_pkg::DEF_NUM_PIXELS,
    parameter int DESC_DEPTH = lspg_pkg::DEF_DESC_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             force_update,
    input  logic                             pop,
    output logic                             empty,
    output logic [lspg_pkg::IDX_W-1:0]       pixel_index,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             last_pixel,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lspg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lspg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic fifo_full;
    logic fifo_nonempty;
    logic desc_push;
    logic desc_take;
    lspg_pkg::frame_desc_t desc_in;
    lspg_pkg::frame_desc_t desc_out;

    assign full = fifo_full;

    lspg_front #(
        .NUM_PIXELS(NUM_PIXELS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .force_update(force_update),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fifo_full(fifo_full),
        .desc_push(desc_push),
        .desc(desc_in)
    );

    lspg_desc_fifo #(
        .DEPTH(DESC_DEPTH)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(desc_push),
        .wr_data(desc_in),
        .full(fifo_full),
        .rd_en(desc_take),
        .rd_data(desc_out),
        .nonempty(fifo_nonempty)
    );

    lspg_back #(
        .NUM_PIXELS(NUM_PIXELS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .desc_nonempty(fifo_nonempty),
        .desc(desc_out),
        .desc_take(desc_take),
        .pop(pop),
        .empty(empty),
        .pixel_index(pixel_index),
        .red(red),
        .green(green),
        .blue(blue),
        .last_pixel(last_pixel)
    );

endmodule
